// ===== rtl/core/multi_slot_expiry_timer_bank_assert.svh =====
// Assertion macros for the timer bank RTL.
`ifndef MULTI_SLOT_EXPIRY_TIMER_BANK_ASSERT_SVH
`define MULTI_SLOT_EXPIRY_TIMER_BANK_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MSET_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MSET_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mset_pkg.sv =====
// Shared types and constants for the expiry timer bank.
package mset_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int ARG_W          = 16;
  localparam int MODE_W         = 2;
  localparam int SLOT_W         = ARG_W + MODE_W;
  localparam int TIME_W         = 32;
  localparam int IDX_W          = 8;

  typedef enum logic [2:0] {
    CMD_RESET   = 3'd0,
    CMD_CONFIG  = 3'd1,
    CMD_START   = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_EXEC    = 3'd4,
    CMD_DELETE  = 3'd5,
    CMD_QUERY   = 3'd6,
    CMD_REFRESH = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_UNUSED    = 2'd0,
    MODE_STOPPED   = 2'd1,
    MODE_RUNNING   = 2'd2,
    MODE_COMPLETED = 2'd3
  } mode_t;

  // Controller to datapath strobes
  typedef struct packed {
    logic accept;
    logic mod;
    logic scan;
    logic emit;
    logic resp;
  } dp_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t cmd;
    logic scan_done;
    logic emit_pend;
    logic emit_done;
  } dp_stat_t;

endpackage

// ===== rtl/core/multi_slot_expiry_timer_bank.sv =====
// Top level of the multi-slot expiry timer bank.
//
// Usage:
//   A request (in_cmd, in_slot_index, in_param_value, in_duration_ms,
//   in_now_ms) is taken on a rising edge with start high and busy low.
//   Results appear on the out_* ports for one cycle each, flagged by
//   out_valid; the receiver must take them, there is no stall.
//   Every request ends with exactly one response (out_last = 1). Expiry
//   events (out_is_expiry = 1) come first, lowest slot first.
//   out_next_expiry is the earliest running deadline as rebuilt by the last request other than exec or query.
// Timing:
//   exec and query take the short path (read, modify, respond); every
//   other request also runs the earliest-deadline rebuild, which walks the
//   slot RAM one entry per cycle through its single read port. A refresh
//   that completes slots also replays their events before the response.
//   The response trails the controller by one register stage.
// Reset:
//   rst_n clears all slots to unused with parameter 0 at once (per-slot
//   valid bits); deadlines are not cleared and no clearing pass runs.
module multi_slot_expiry_timer_bank
  import mset_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_cmd,
  input  logic [IDX_W-1:0]  in_slot_index,
  input  logic [ARG_W-1:0]  in_param_value,
  input  logic [TIME_W-1:0] in_duration_ms,
  input  logic [TIME_W-1:0] in_now_ms,
  // result channel
  output logic              out_valid,
  output logic              out_is_expiry,
  output logic [IDX_W-1:0]  out_index,
  output logic [ARG_W-1:0]  out_param,
  output logic [1:0]        out_slot_status,
  output logic [TIME_W-1:0] out_next_expiry,
  output logic              out_last
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  // sequencer: one request at a time
  mset_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl),
    .stat  (stat)
  );

  // slot RAMs, scan and result registers
  mset_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .in_cmd          (in_cmd),
    .in_slot_index   (in_slot_index),
    .in_param_value  (in_param_value),
    .in_duration_ms  (in_duration_ms),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_is_expiry   (out_is_expiry),
    .out_index       (out_index),
    .out_param       (out_param),
    .out_slot_status (out_slot_status),
    .out_next_expiry (out_next_expiry),
    .out_last        (out_last)
  );

`include "multi_slot_expiry_timer_bank_assert.svh"

  `MSET_ASSERT_NXT(a_busy_after_accept, clk, rst_n, start && !busy, busy, "busy not raised")
  `MSET_ASSERT_NXT(a_resp_closes, clk, rst_n, out_valid && out_last, !out_valid, "result after response")
  `MSET_ASSERT_IMP(a_event_form, clk, rst_n, out_valid && out_is_expiry, !out_last && out_slot_status == MODE_COMPLETED, "bad expiry event")
  `MSET_ASSERT_IMP(a_result_in_request, clk, rst_n, out_valid, $past(busy), "result outside request")

endmodule

// ===== rtl/core/mset_ram.sv =====
// Generic one-write one-read RAM with registered read data.
module mset_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/mset_ctrl.sv =====
// Request sequencer for the expiry timer bank.
module mset_ctrl
  import mset_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output dp_ctl_t  ctl,
  input  dp_stat_t stat
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_MOD  = 6'b000100,
    ST_SCAN = 6'b001000,
    ST_EMIT = 6'b010000,
    ST_RESP = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.accept = 1'b1;
          state_nxt  = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        ctl.mod = 1'b1;
        if (stat.cmd inside {CMD_EXEC, CMD_QUERY}) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = stat.emit_pend ? ST_EMIT : ST_RESP;
        end
      end
      ST_EMIT: begin
        ctl.emit = 1'b1;
        if (stat.emit_done) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        ctl.resp  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/core/mset_dp.sv =====
// Slot storage, scan logic and result registers of the expiry timer bank.
module mset_dp
  import mset_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_ctl_t           ctl,
  output dp_stat_t          stat,
  input  logic [2:0]        in_cmd,
  input  logic [IDX_W-1:0]  in_slot_index,
  input  logic [ARG_W-1:0]  in_param_value,
  input  logic [TIME_W-1:0] in_duration_ms,
  input  logic [TIME_W-1:0] in_now_ms,
  output logic              out_valid,
  output logic              out_is_expiry,
  output logic [IDX_W-1:0]  out_index,
  output logic [ARG_W-1:0]  out_param,
  output logic [1:0]        out_slot_status,
  output logic [TIME_W-1:0] out_next_expiry,
  output logic              out_last
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  // request fields
  cmd_t              cmd_r, cmd_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [ARG_W-1:0]  par_r, par_nxt;
  logic [TIME_W-1:0] dur_r, dur_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              ok_r, ok_nxt;

  // bank state
  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;
  logic                  vq_r, vq_nxt;
  logic [TIME_W-1:0]     prev_r, prev_nxt;
  logic                  back_r, back_nxt;
  logic [TIME_W-1:0]     earliest_r, earliest_nxt;

  // response capture
  mode_t             resp_mode_r, resp_mode_nxt;
  logic [ARG_W-1:0]  resp_arg_r, resp_arg_nxt;

  // scan and event sequencing
  logic [CW-1:0]         scan_cnt_r, scan_cnt_nxt;
  logic                  evl_vld_r, evl_vld_nxt;
  logic [AW-1:0]         evl_idx_r, evl_idx_nxt;
  logic [SLOT_COUNT-1:0] mask_r, mask_nxt;
  logic                  emit_vld_r, emit_vld_nxt;
  logic [AW-1:0]         emit_idx_r, emit_idx_nxt;
  logic [SLOT_COUNT-1:0] low_oh;
  logic [AW-1:0]         low_idx;

  // result registers
  logic              out_valid_r, out_valid_nxt;
  logic              out_exp_r, out_exp_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [ARG_W-1:0]  out_par_r, out_par_nxt;
  mode_t             out_st_r, out_st_nxt;
  logic              out_last_r, out_last_nxt;

  // memory ports
  logic              ma_we;
  logic [AW-1:0]     ma_waddr;
  logic [SLOT_W-1:0] ma_wdata;
  logic [SLOT_W-1:0] ma_rdata;
  logic              dl_we;
  logic [TIME_W-1:0] dl_rdata;
  logic [AW-1:0]     raddr;

  mode_t             cur_mode;
  logic [ARG_W-1:0]  cur_arg;
  mode_t             new_mode;
  logic [ARG_W-1:0]  new_arg;
  logic              slot_wr;

  mset_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (ma_we),
    .waddr (ma_waddr),
    .wdata (ma_wdata),
    .raddr (raddr),
    .rdata (ma_rdata)
  );

  mset_ram #(.WIDTH(TIME_W), .DEPTH(SLOT_COUNT)) u_deadline_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (idx_r[AW-1:0]),
    .wdata (now_r + dur_r),
    .raddr (raddr),
    .rdata (dl_rdata)
  );

  // entry never written since the last clear reads as unused, arg 0
  assign cur_mode = vq_r ? mode_t'(ma_rdata[SLOT_W-1:ARG_W]) : MODE_UNUSED;
  assign cur_arg  = vq_r ? ma_rdata[ARG_W-1:0] : '0;

  // lowest pending event
  assign low_oh = mask_r & (~mask_r + SLOT_COUNT'(1));

  always_comb begin
    low_idx = '0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (low_oh[k]) begin
        low_idx = low_idx | AW'(k);
      end
    end
  end

  // single-slot update
  always_comb begin
    new_mode = cur_mode;
    new_arg  = cur_arg;
    slot_wr  = 1'b0;
    case (cmd_r)
      CMD_CONFIG: begin
        new_mode = MODE_STOPPED;
        new_arg  = par_r;
        slot_wr  = ok_r;
      end
      CMD_START: begin
        new_mode = MODE_RUNNING;
        new_arg  = par_r;
        slot_wr  = ok_r;
      end
      CMD_STOP: begin
        if (cur_mode != MODE_UNUSED) begin
          new_mode = MODE_STOPPED;
        end
        slot_wr = ok_r;
      end
      CMD_EXEC: begin
        if (cur_mode == MODE_RUNNING) begin
          new_mode = MODE_COMPLETED;
          slot_wr  = ok_r;
        end
      end
      CMD_DELETE: begin
        new_mode = MODE_UNUSED;
        slot_wr  = ok_r;
      end
      default: begin
        slot_wr = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    par_nxt       = par_r;
    dur_nxt       = dur_r;
    now_nxt       = now_r;
    ok_nxt        = ok_r;
    valid_nxt     = valid_r;
    prev_nxt      = prev_r;
    back_nxt      = back_r;
    earliest_nxt  = earliest_r;
    resp_mode_nxt = resp_mode_r;
    resp_arg_nxt  = resp_arg_r;
    scan_cnt_nxt  = scan_cnt_r;
    evl_vld_nxt   = evl_vld_r;
    evl_idx_nxt   = evl_idx_r;
    mask_nxt      = mask_r;
    emit_vld_nxt  = emit_vld_r;
    emit_idx_nxt  = emit_idx_r;
    out_valid_nxt = 1'b0;
    out_exp_nxt   = out_exp_r;
    out_idx_nxt   = out_idx_r;
    out_par_nxt   = out_par_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    ma_we         = 1'b0;
    ma_waddr      = idx_r[AW-1:0];
    ma_wdata      = {new_mode, new_arg};
    dl_we         = 1'b0;
    raddr         = idx_r[AW-1:0];

    if (ctl.accept) begin
      cmd_nxt = cmd_t'(in_cmd);
      idx_nxt = in_slot_index;
      par_nxt = in_param_value;
      dur_nxt = in_duration_ms;
      now_nxt = in_now_ms;
      ok_nxt  = (32'(in_slot_index) < 32'(SLOT_COUNT));
      raddr   = in_slot_index[AW-1:0];
    end

    if (ctl.mod) begin
      ma_we = slot_wr;
      dl_we = ok_r && (cmd_r == CMD_START);
      if (slot_wr) begin
        valid_nxt[idx_r[AW-1:0]] = 1'b1;
      end
      if (cmd_r == CMD_RESET) begin
        valid_nxt = '0;
        prev_nxt  = '0;
      end
      if (cmd_r == CMD_REFRESH) begin
        back_nxt = (now_r < prev_r);
        prev_nxt = now_r;
      end
      if (ok_r && cmd_r != CMD_RESET) begin
        resp_mode_nxt = new_mode;
        resp_arg_nxt  = new_arg;
      end else begin
        resp_mode_nxt = MODE_UNUSED;
        resp_arg_nxt  = '0;
      end
      // exec hit: event goes out before the response
      if (cmd_r == CMD_EXEC && slot_wr) begin
        out_valid_nxt = 1'b1;
        out_exp_nxt   = 1'b1;
        out_idx_nxt   = idx_r;
        out_par_nxt   = cur_arg;
        out_st_nxt    = MODE_COMPLETED;
        out_last_nxt  = 1'b0;
      end
      scan_cnt_nxt = '0;
      evl_vld_nxt  = 1'b0;
      mask_nxt     = '0;
      emit_vld_nxt = 1'b0;
      if (!(cmd_r inside {CMD_EXEC, CMD_QUERY})) begin
        earliest_nxt = '0;
      end
    end

    if (ctl.scan) begin
      // read slot k while slot k-1 is evaluated
      if (scan_cnt_r != CW'(SLOT_COUNT)) begin
        raddr        = scan_cnt_r[AW-1:0];
        evl_vld_nxt  = 1'b1;
        evl_idx_nxt  = scan_cnt_r[AW-1:0];
        scan_cnt_nxt = scan_cnt_r + CW'(1);
      end else begin
        evl_vld_nxt = 1'b0;
      end
      if (evl_vld_r && cur_mode == MODE_RUNNING) begin
        if (cmd_r == CMD_REFRESH && (back_r || dl_rdata <= now_r)) begin
          ma_we               = 1'b1;
          ma_waddr            = evl_idx_r;
          ma_wdata            = {MODE_COMPLETED, cur_arg};
          mask_nxt[evl_idx_r] = 1'b1;
          if (ok_r && evl_idx_r == idx_r[AW-1:0]) begin
            resp_mode_nxt = MODE_COMPLETED;
          end
        end else if (earliest_r == '0 || dl_rdata < earliest_r) begin
          // zero reads as none, so any later deadline replaces it
          earliest_nxt = dl_rdata;
        end
      end
    end

    if (ctl.emit) begin
      if (mask_r != '0) begin
        raddr        = low_idx;
        mask_nxt     = mask_r & ~low_oh;
        emit_vld_nxt = 1'b1;
        emit_idx_nxt = low_idx;
      end else begin
        emit_vld_nxt = 1'b0;
      end
      if (emit_vld_r) begin
        out_valid_nxt = 1'b1;
        out_exp_nxt   = 1'b1;
        out_idx_nxt   = IDX_W'(emit_idx_r);
        out_par_nxt   = cur_arg;
        out_st_nxt    = MODE_COMPLETED;
        out_last_nxt  = 1'b0;
      end
    end

    if (ctl.resp) begin
      out_valid_nxt = 1'b1;
      out_exp_nxt   = 1'b0;
      out_idx_nxt   = idx_r;
      out_par_nxt   = resp_arg_r;
      out_st_nxt    = resp_mode_r;
      out_last_nxt  = 1'b1;
    end
  end

  // valid bit follows the read address into the data cycle
  assign vq_nxt = (32'(raddr) < 32'(SLOT_COUNT)) ? valid_r[raddr] : 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      prev_r      <= '0;
      back_r      <= 1'b0;
      earliest_r  <= '0;
      scan_cnt_r  <= '0;
      evl_vld_r   <= 1'b0;
      mask_r      <= '0;
      emit_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cmd_r       <= CMD_QUERY;
    end else begin
      valid_r     <= valid_nxt;
      prev_r      <= prev_nxt;
      back_r      <= back_nxt;
      earliest_r  <= earliest_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      evl_vld_r   <= evl_vld_nxt;
      mask_r      <= mask_nxt;
      emit_vld_r  <= emit_vld_nxt;
      out_valid_r <= out_valid_nxt;
      cmd_r       <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    par_r       <= par_nxt;
    dur_r       <= dur_nxt;
    now_r       <= now_nxt;
    ok_r        <= ok_nxt;
    vq_r        <= vq_nxt;
    resp_mode_r <= resp_mode_nxt;
    resp_arg_r  <= resp_arg_nxt;
    evl_idx_r   <= evl_idx_nxt;
    emit_idx_r  <= emit_idx_nxt;
    out_exp_r   <= out_exp_nxt;
    out_idx_r   <= out_idx_nxt;
    out_par_r   <= out_par_nxt;
    out_st_r    <= out_st_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign stat.cmd       = cmd_r;
  assign stat.scan_done = (scan_cnt_r == CW'(SLOT_COUNT)) && evl_vld_r;
  assign stat.emit_pend = (mask_nxt != '0);
  assign stat.emit_done = (mask_r == '0);

  assign out_valid       = out_valid_r;
  assign out_is_expiry   = out_exp_r;
  assign out_index       = out_idx_r;
  assign out_param       = out_par_r;
  assign out_slot_status = out_st_r;
  assign out_next_expiry = earliest_r;
  assign out_last        = out_last_r;

endmodule

// ===== tb/sv/expiry_check_pkg.sv =====
// Scoreboard class with its own model of the expiry timer bank.
`timescale 1ns / 100ps
package expiry_check_pkg;
  import mset_pkg::*;

  localparam int BANK_SLOTS = SLOT_COUNT_DEF;

  typedef struct {
    bit               is_expiry;
    logic [IDX_W-1:0] index;
    logic [ARG_W-1:0] param;
    mode_t            status;
    logic [TIME_W-1:0] next_exp;
    bit               last;
  } bank_reply_t;

  class expiry_scoreboard;
    mode_t             slot_mode [BANK_SLOTS];
    logic [ARG_W-1:0]  slot_arg [BANK_SLOTS];
    logic [TIME_W-1:0] slot_deadline [BANK_SLOTS];
    logic [TIME_W-1:0] last_refresh_ms;
    logic [TIME_W-1:0] earliest_ms;
    bank_reply_t       awaited [$];
    int                fails;

    function new();
      foreach (slot_mode[k]) begin
        slot_mode[k]     = MODE_UNUSED;
        slot_arg[k]      = '0;
        slot_deadline[k] = '0;
      end
      last_refresh_ms = '0;
      earliest_ms     = '0;
      fails           = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // A zero deadline reads as "none" and is overridden by later slots.
    function logic [TIME_W-1:0] earliest_running();
      logic [TIME_W-1:0] best;
      best = '0;
      for (int k = 0; k < BANK_SLOTS; k++) begin
        if (slot_mode[k] == MODE_RUNNING) begin
          if (best != 0 && slot_deadline[k] < best) best = slot_deadline[k];
          if (best == 0) best = slot_deadline[k];
        end
      end
      return best;
    endfunction

    function bank_reply_t make_reply(bit is_exp, logic [IDX_W-1:0] idx,
                                     logic [ARG_W-1:0] par, mode_t st, bit lst);
      bank_reply_t r;
      r.is_expiry = is_exp;
      r.index     = idx;
      r.param     = par;
      r.status    = st;
      r.next_exp  = '0;
      r.last      = lst;
      return r;
    endfunction

    function void note_request(cmd_t cmd, logic [IDX_W-1:0] idx, logic [ARG_W-1:0] par,
                               logic [TIME_W-1:0] dur, logic [TIME_W-1:0] now);
      bank_reply_t batch [$];
      bank_reply_t resp;
      bit          hit;
      bit          went_back;
      hit = idx < BANK_SLOTS;
      case (cmd)
        CMD_RESET: begin
          last_refresh_ms = '0;
          foreach (slot_mode[k]) begin
            slot_mode[k] = MODE_UNUSED;
            slot_arg[k]  = '0;
          end
          earliest_ms = earliest_running();
        end
        CMD_CONFIG: begin
          if (hit) begin
            slot_arg[idx]  = par;
            slot_mode[idx] = MODE_STOPPED;
          end
          earliest_ms = earliest_running();
        end
        CMD_START: begin
          if (hit) begin
            slot_arg[idx]      = par;
            slot_deadline[idx] = now + dur;
            slot_mode[idx]     = MODE_RUNNING;
          end
          earliest_ms = earliest_running();
        end
        CMD_STOP: begin
          if (hit && slot_mode[idx] != MODE_UNUSED) slot_mode[idx] = MODE_STOPPED;
          earliest_ms = earliest_running();
        end
        CMD_EXEC: begin
          if (hit && slot_mode[idx] == MODE_RUNNING) begin
            slot_mode[idx] = MODE_COMPLETED;
            batch.push_back(make_reply(1'b1, idx, slot_arg[idx], MODE_COMPLETED, 1'b0));
          end
        end
        CMD_DELETE: begin
          if (hit) slot_mode[idx] = MODE_UNUSED;
          earliest_ms = earliest_running();
        end
        CMD_QUERY: ;
        default: begin
          went_back = now < last_refresh_ms;
          for (int k = 0; k < BANK_SLOTS; k++) begin
            if (slot_mode[k] == MODE_RUNNING && (went_back || slot_deadline[k] <= now)) begin
              slot_mode[k] = MODE_COMPLETED;
              batch.push_back(make_reply(1'b1, k[IDX_W-1:0], slot_arg[k],
                                         MODE_COMPLETED, 1'b0));
            end
          end
          last_refresh_ms = now;
          earliest_ms     = earliest_running();
        end
      endcase
      if (hit) resp = make_reply(1'b0, idx, slot_arg[idx], slot_mode[idx], 1'b1);
      else resp = make_reply(1'b0, idx, '0, MODE_UNUSED, 1'b1);
      batch.push_back(resp);
      foreach (batch[k]) begin
        batch[k].next_exp = earliest_ms;
        awaited.push_back(batch[k]);
      end
    endfunction

    function void check_result(logic is_exp, logic [IDX_W-1:0] idx, logic [ARG_W-1:0] par,
                               logic [1:0] st, logic [TIME_W-1:0] nxt, logic lst);
      bank_reply_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: index %0d, last %0b", idx, lst);
        fails++;
        return;
      end
      want = awaited.pop_front();
      if (is_exp !== want.is_expiry) begin
        $error("out_is_expiry: expected %0b, got %0b", want.is_expiry, is_exp);
        fails++;
      end
      if (idx !== want.index) begin
        $error("out_index: expected %0d, got %0d", want.index, idx);
        fails++;
      end
      if (par !== want.param) begin
        $error("out_param: expected %h, got %h", want.param, par);
        fails++;
      end
      if (st !== want.status) begin
        $error("out_slot_status: expected %0d, got %0d", want.status, st);
        fails++;
      end
      if (nxt !== want.next_exp) begin
        $error("out_next_expiry: expected %h, got %h", want.next_exp, nxt);
        fails++;
      end
      if (lst !== want.last) begin
        $error("out_last: expected %0b, got %0b", want.last, lst);
        fails++;
      end
    endfunction
  endclass
endpackage

// ===== tb/sv/testbench.sv =====
// Top-level testbench: drives requests into the timer bank and checks every result.
`timescale 1ns / 100ps
module testbench;
  import mset_pkg::*;
  import expiry_check_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [2:0]        in_cmd;
  logic [IDX_W-1:0]  in_slot_index;
  logic [ARG_W-1:0]  in_param_value;
  logic [TIME_W-1:0] in_duration_ms;
  logic [TIME_W-1:0] in_now_ms;
  logic              out_valid;
  logic              out_is_expiry;
  logic [IDX_W-1:0]  out_index;
  logic [ARG_W-1:0]  out_param;
  logic [1:0]        out_slot_status;
  logic [TIME_W-1:0] out_next_expiry;
  logic              out_last;

  expiry_scoreboard bank_sb;

  // Millisecond wall clock for the random requests; it never moves back.
  logic [TIME_W-1:0] wall_ms;
  // Cleared during the burst stretch so requests go back to back.
  bit                gaps_on;

  multi_slot_expiry_timer_bank dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_slot_index   (in_slot_index),
    .in_param_value  (in_param_value),
    .in_duration_ms  (in_duration_ms),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_is_expiry   (out_is_expiry),
    .out_index       (out_index),
    .out_param       (out_param),
    .out_slot_status (out_slot_status),
    .out_next_expiry (out_next_expiry),
    .out_last        (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Monitor: everything is sampled on the rising edge. Results are checked
  // before the request taken on the same edge is noted; a result always
  // trails its own request by at least one register stage.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        bank_sb.check_result(out_is_expiry, out_index, out_param, out_slot_status,
                             out_next_expiry, out_last);
      if (start && !busy)
        bank_sb.note_request(cmd_t'(in_cmd), in_slot_index, in_param_value,
                             in_duration_ms, in_now_ms);
    end
  end

  // Called on a falling edge. start stays high on return, so a following
  // request can go out back to back without start dropping.
  task automatic send_request(cmd_t cmd, logic [IDX_W-1:0] idx, logic [ARG_W-1:0] par,
                              logic [TIME_W-1:0] dur, logic [TIME_W-1:0] now);
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_slot_index  <= idx;
    in_param_value <= par;
    in_duration_ms <= dur;
    in_now_ms      <= now;
    // busy only moves on the rising edge, so its value here holds
    // through the next edge: low now means taken at that edge.
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // Random sender gap, in about 36 of a hundred requests.
  task automatic maybe_idle();
    if (gaps_on && $urandom_range(99) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  // Hold off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (bank_sb.pending() != 0);
  endtask

  task automatic send_paced(cmd_t cmd, logic [IDX_W-1:0] idx, logic [ARG_W-1:0] par,
                            logic [TIME_W-1:0] dur, logic [TIME_W-1:0] now);
    maybe_idle();
    send_request(cmd, idx, par, dur, now);
  endtask

  // One random request. Mostly in-range slots on a sane time base, so that
  // timers actually run and expire; a few pure-noise requests on top.
  task automatic random_request();
    cmd_t              cmd;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] now;
    int                pick;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 6) begin
      send_paced(cmd_t'(3'($urandom_range(7))), IDX_W'($urandom_range(255)),
                 ARG_W'($urandom), $urandom, $urandom);
    end else begin
      if (pick < 30) cmd = CMD_START;
      else if (pick < 50) cmd = CMD_REFRESH;
      else if (pick < 60) cmd = CMD_EXEC;
      else if (pick < 68) cmd = CMD_STOP;
      else if (pick < 76) cmd = CMD_CONFIG;
      else if (pick < 83) cmd = CMD_DELETE;
      else if (pick < 97) cmd = CMD_QUERY;
      else cmd = CMD_RESET;
      if ($urandom_range(9) == 0) idx = IDX_W'($urandom_range(255, BANK_SLOTS));
      else idx = IDX_W'($urandom_range(BANK_SLOTS - 1));
      dur = ($urandom_range(7) == 0) ? $urandom : $urandom_range(150);
      now = wall_ms;
      if (cmd == CMD_REFRESH) begin
        // occasionally the clock steps back; if it lands before the last refresh, everything running completes
        if ($urandom_range(9) == 0) now = wall_ms - $urandom_range(1, 300);
        else begin
          wall_ms = wall_ms + $urandom_range(60);
          now     = wall_ms;
        end
      end
      send_paced(cmd, idx, ARG_W'($urandom), dur, now);
    end
  endtask

  initial begin
    bank_sb        = new();
    rst_n          = 1'b0;
    start          = 1'b0;
    in_cmd         = CMD_QUERY;
    in_slot_index  = '0;
    in_param_value = '0;
    in_duration_ms = '0;
    in_now_ms      = '0;
    gaps_on        = 1'b1;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part.
    send_paced(CMD_QUERY,   8'd0,   16'h0000, 32'd0,        32'd0);        // empty bank
    send_paced(CMD_CONFIG,  8'd0,   16'hFFFF, 32'd0,        32'd0);
    send_paced(CMD_START,   8'd1,   16'h1234, 32'd100,      32'd1000);
    send_paced(CMD_START,   8'd7,   16'h0000, 32'hFFFF_FFFF, 32'd5);       // deadline wraps
    send_paced(CMD_START,   8'd2,   16'h8001, 32'd0,        32'd0);        // zero deadline
    send_paced(CMD_STOP,    8'd3,   16'h0000, 32'd0,        32'd0);        // unused slot
    send_paced(CMD_EXEC,    8'd1,   16'h0000, 32'd0,        32'd0);        // fires event
    send_paced(CMD_EXEC,    8'd0,   16'h0000, 32'd0,        32'd0);        // not running
    send_paced(CMD_QUERY,   8'd255, 16'h0000, 32'd0,        32'd0);        // out of range
    send_paced(CMD_START,   8'd200, 16'h5555, 32'd10,       32'd10);       // out of range
    send_paced(CMD_DELETE,  8'd8,   16'h0000, 32'd0,        32'd0);        // out of range
    send_paced(CMD_REFRESH, 8'd0,   16'h0000, 32'd0,        32'd3);
    send_paced(CMD_REFRESH, 8'd7,   16'h0000, 32'd0,        32'd1);        // time went back
    send_paced(CMD_STOP,    8'd2,   16'h0000, 32'd0,        32'd0);        // completed -> stopped
    send_paced(CMD_DELETE,  8'd0,   16'h0000, 32'd0,        32'd0);
    send_paced(CMD_QUERY,   8'd0,   16'h0000, 32'd0,        32'd0);        // param kept
    send_paced(CMD_RESET,   8'd9,   16'h0000, 32'd0,        32'd0);
    // Fill every slot, then expire them all in one refresh.
    for (int k = 0; k < BANK_SLOTS; k++)
      send_paced(CMD_START, k[IDX_W-1:0], ARG_W'(16'hA000 + k),
                 TIME_W'((BANK_SLOTS - k) * 3), 32'd2000);
    send_paced(CMD_REFRESH, 8'd3,   16'h0000, 32'd0,        32'hFFFF_FFFF);

    drain_results();

    // Random part, with a gap-free stretch in the middle.
    wall_ms = $urandom_range(2000);
    for (int n = 0; n < 85; n++) begin
      gaps_on = !(n >= 30 && n < 58);
      if (n == 45) drain_results();
      random_request();
    end

    drain_results();
    repeat (40) @(negedge clk);
    if (bank_sb.fails == 0 && bank_sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mset_pkg.sv
rtl/core/mset_ram.sv
rtl/core/mset_ctrl.sv
rtl/core/mset_dp.sv
rtl/core/multi_slot_expiry_timer_bank.sv
tb/sv/expiry_check_pkg.sv
tb/sv/testbench.sv
